// ===== design/bbd_pkg.sv =====
// Shared types and constants for the bilinear Bayer demosaic.
// No dependencies.
`default_nettype none

package bbd_pkg;

    localparam int RAW_W     = 16;
    localparam int PIX_W     = 8;
    localparam int POS_W     = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int SIZE_W    = 13;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [CFG_W-1:0]  FRAME_WIDTH_RST  = 12'd1280;
    localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RST = 12'd960;
    localparam logic [SIZE_W-1:0] MIN_SIZE         = 13'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_sample;
        logic             start_of_frame;
    } raw_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [POS_W-1:0] pixel_column;
        logic [POS_W-1:0] pixel_row;
        logic             end_of_frame;
        logic             last_of_item;
    } rgb_item_t;

endpackage

`default_nettype wire

// ===== design/bbd_in_if.sv =====
// Raw sample channel: valid/ready handshake with raw_item_t payload.
// Depends on bbd_pkg.
`default_nettype none

interface bbd_in_if;
    import bbd_pkg::*;

    logic      valid;
    logic      ready;
    raw_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== design/bbd_out_if.sv =====
// RGB pixel channel: valid/ready handshake with rgb_item_t payload.
// Depends on bbd_pkg.
`default_nettype none

interface bbd_out_if;
    import bbd_pkg::*;

    logic      valid;
    logic      ready;
    rgb_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== design/bbd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bayer_bilinear_demosaic.sv =====
// Bilinear GRBG demosaic. A quad's completing sample is registered in the sample stage,
// then the quad goes into the quad buffer; its four pixels follow one per cycle while the
// output is ready. Throughput: one sample per cycle while no quad is pending; the output
// port sets the pace, as a completing sample waits in the sample stage for a pending quad.
// Reset: counters to zero, size 1280x960, pipeline emptied; line stores keep their contents.
// Depends on bbd_pkg, bbd_in_if, bbd_out_if, bbd_ram.
`default_nettype none

module bayer_bilinear_demosaic
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    bbd_in_if.sink               pix_in,
    bbd_out_if.source            pix_out
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] W_TOP = SIZE_W'(MAX_WIDTH & ~1);
    localparam logic [SIZE_W-1:0] H_TOP = SIZE_W'(MAX_HEIGHT & ~1);

    // configuration
    logic [CFG_W-1:0]  fw_reg, fh_reg;
    logic [SIZE_W-1:0] fw_even, fh_even, w, h;

    // position
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [SIZE_W-1:0] c0, r0, cn, rn, qx, qy;
    logic              edge_q, emit, is_eof;
    logic              accept;
    logic [PIX_W-1:0]  pix;

    // sample stage
    logic              s1_valid_reg, s1_valid_next, s1_go;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [1:0]        s1_bank_reg;
    logic              s1_emit_reg, s1_border_reg, s1_xzero_reg, s1_eof_reg;
    logic [POS_W-1:0]  s1_x_reg, s1_y_reg;

    // line stores and window
    logic [PIX_W-1:0]  ram_rdata [4];
    logic [PIX_W-1:0]  win_reg [4][3];
    logic [PIX_W-1:0]  first_reg [4];
    logic [PIX_W-1:0]  cur0_reg, cur1_reg;
    logic [1:0]        p1, p2, p3;
    logic [PIX_W-1:0]  ta [4], tb [4], tc [4];
    logic [PIX_W-1:0]  g0b, gmb;

    // quad buffer
    logic              q_valid_reg, q_valid_next, q_load, out_xfer, q_last;
    logic [1:0]        q_k_reg;
    logic [PIX_W-1:0]  q_r_reg [4], q_g_reg [4], q_b_reg [4];
    logic [PIX_W-1:0]  nr [4], ng [4], nb [4];
    logic [POS_W-1:0]  q_x_reg, q_y_reg;
    logic              q_eof_reg;

    function automatic logic [PIX_W-1:0] avg2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W:1];
    endfunction

    function automatic logic [PIX_W-1:0] avg4(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                              logic [PIX_W-1:0] c, logic [PIX_W-1:0] d);
        logic [PIX_W+1:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        return s[PIX_W+1:2];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  fw_reg <= cfg_data;
                CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        fw_even = {1'b0, fw_reg[CFG_W-1:1], 1'b0};
        fh_even = {1'b0, fh_reg[CFG_W-1:1], 1'b0};
        w = (fw_even < MIN_SIZE) ? MIN_SIZE : ((fw_even > W_TOP) ? W_TOP : fw_even);
        h = (fh_even < MIN_SIZE) ? MIN_SIZE : ((fh_even > H_TOP) ? H_TOP : fh_even);
    end

    assign out_xfer = pix_out.valid && pix_out.ready;
    assign q_last   = out_xfer && (q_k_reg == 2'd3);
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || !q_valid_reg || q_last);
    assign q_load   = s1_go && s1_emit_reg;
    assign pix_in.ready = !s1_valid_reg || s1_go;
    assign accept   = pix_in.valid && pix_in.ready;
    assign pix      = pix_in.item.raw_sample[11:4];

    always_comb
    begin
        c0 = pix_in.item.start_of_frame ? '0 : SIZE_W'(col_reg);
        r0 = pix_in.item.start_of_frame ? '0 : SIZE_W'(row_reg);
        if (c0 >= w)
        begin
            c0 = '0;
            r0 = r0 + 1'b1;
        end
        if (r0 >= h)
        begin
            r0 = '0;
        end
        cn = c0 + 1'b1;
        rn = r0 + 1'b1;
        if (cn >= w)
        begin
            col_next = '0;
            row_next = (rn >= h) ? '0 : rn[RW-1:0];
        end
        else
        begin
            col_next = cn[CW-1:0];
            row_next = r0[RW-1:0];
        end
        qx     = c0 - 1'b1;
        qy     = r0[0] ? (r0 - 1'b1) : (r0 - 2'd2);
        edge_q = (qx == '0) || (qy == '0) || (qx == w - 2'd2) || (qy == h - 2'd2);
        emit   = c0[0] && (r0[0] ? edge_q : ((r0 >= 2'd2) && !edge_q));
        is_eof = (qx + 2'd2 == w) && (qy + 2'd2 == h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            q_valid_reg  <= 1'b0;
            q_k_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            q_valid_reg  <= q_valid_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (q_load)
            begin
                q_k_reg <= '0;
            end
            else if (out_xfer)
            begin
                q_k_reg <= q_k_reg + 1'b1;
            end
        end
    end

    assign s1_valid_next = accept || (s1_valid_reg && !s1_go);
    assign q_valid_next  = q_load || (q_valid_reg && !q_last);

    for (genvar b = 0; b < 4; b++)
    begin : g_line
        bbd_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (accept && (r0[1:0] == 2'(b))),
            .waddr (c0[CW-1:0]),
            .wdata (pix),
            .re    (accept),
            .raddr (cn[CW-1:0]),
            .rdata (ram_rdata[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg    <= pix;
            s1_bank_reg   <= r0[1:0];
            s1_emit_reg   <= emit;
            s1_border_reg <= r0[0];
            s1_xzero_reg  <= (qx == '0);
            s1_eof_reg    <= is_eof;
            s1_x_reg      <= qx[POS_W-1:0];
            s1_y_reg      <= qy[POS_W-1:0];
            cur0_reg      <= cur1_reg;
            cur1_reg      <= s1_pix_reg;
            for (int b = 0; b < 4; b++)
            begin
                win_reg[b][0] <= win_reg[b][1];
                win_reg[b][1] <= win_reg[b][2];
                win_reg[b][2] <= ram_rdata[b];
            end
            if (c0 == '0)
            begin
                first_reg[r0[1:0]] <= pix;
            end
        end
        if (q_load)
        begin
            q_r_reg   <= nr;
            q_g_reg   <= ng;
            q_b_reg   <= nb;
            q_x_reg   <= s1_x_reg;
            q_y_reg   <= s1_y_reg;
            q_eof_reg <= s1_eof_reg;
        end
    end

    // ta/tb/tc: rows y-1, y, y+1 of an interior quad; taps at columns x-1 .. x+2
    always_comb
    begin
        p1 = s1_bank_reg - 2'd1;
        p2 = s1_bank_reg - 2'd2;
        p3 = s1_bank_reg - 2'd3;
        for (int i = 0; i < 3; i++)
        begin
            ta[i] = win_reg[p3][i];
            tb[i] = win_reg[p2][i];
            tc[i] = win_reg[p1][i];
        end
        ta[3] = ram_rdata[p3];
        tb[3] = ram_rdata[p2];
        tc[3] = ram_rdata[p1];
        g0b   = s1_xzero_reg ? first_reg[p1] : win_reg[p1][1];
        gmb   = avg2(g0b, s1_pix_reg);
        if (s1_border_reg)
        begin
            ng[0] = g0b;
            ng[1] = gmb;
            ng[2] = gmb;
            ng[3] = s1_pix_reg;
            for (int k = 0; k < 4; k++)
            begin
                nr[k] = win_reg[p1][2];
                nb[k] = cur1_reg;
            end
        end
        else
        begin
            nb[0] = avg2(ta[1], tc[1]);
            ng[0] = tb[1];
            nr[0] = avg2(tb[0], tb[2]);
            nb[1] = avg4(ta[1], ta[3], tc[1], tc[3]);
            ng[1] = avg4(ta[2], tc[2], tb[1], tb[3]);
            nr[1] = tb[2];
            nb[2] = tc[1];
            ng[2] = avg4(tb[1], tc[2], tc[0], cur1_reg);
            nr[2] = avg4(tb[0], tb[2], cur0_reg, s1_pix_reg);
            nb[3] = avg2(tc[1], tc[3]);
            ng[3] = tc[2];
            nr[3] = avg2(tb[2], s1_pix_reg);
        end
    end

    assign pix_out.valid             = q_valid_reg;
    assign pix_out.item.red          = q_r_reg[q_k_reg];
    assign pix_out.item.green        = q_g_reg[q_k_reg];
    assign pix_out.item.blue         = q_b_reg[q_k_reg];
    assign pix_out.item.pixel_column = {q_x_reg[POS_W-1:1], q_k_reg[0]};
    assign pix_out.item.pixel_row    = {q_y_reg[POS_W-1:1], q_k_reg[1]};
    assign pix_out.item.end_of_frame = q_eof_reg && (q_k_reg == 2'd3);
    assign pix_out.item.last_of_item = (q_k_reg == 2'd3);

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && pix_out.item.end_of_frame |-> pix_out.item.last_of_item)
        else $error("end of frame away from last pixel of quad");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_pix_reg))
        else $error("stalled sample lost");

    a_k_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_k_reg != 2'd0 |-> q_valid_reg)
        else $error("quad index moved without a pending quad");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("transfer not captured");

endmodule

`default_nettype wire
